// ----- rtl/imheq_pkg.sv -----
// ----------------------------------------------------------------------------
// imheq_pkg: shared types and constants
// Sizes, entry layout and status codes of the edge min-heap.
// ----------------------------------------------------------------------------
package imheq_pkg;
  localparam int unsigned Capacity    = 1024;
  localparam int unsigned VertexCount = 1024;
  localparam int unsigned WeightBits  = 32;
  localparam int unsigned SlotBits    = $clog2(Capacity + 1);
  localparam int unsigned AddrBits    = $clog2(Capacity);
  localparam int unsigned VtxBits     = $clog2(VertexCount);

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusFull  = 2'd2;

  localparam logic OpInsert = 1'b0;
  localparam logic OpRemove = 1'b1;

  typedef struct packed {
    logic [WeightBits-1:0] weight;
    logic [9:0]            to;
    logic [9:0]            from;
  } entry_t;
endpackage

// ----- rtl/imheq_ram.sv -----
// ----------------------------------------------------------------------------
// imheq_ram: generic single-port synchronous RAM
// One write or one read a cycle, registered read data.
// ----------------------------------------------------------------------------
module imheq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

// ----- rtl/indexed_min_heap_edge_queue.sv -----
// ----------------------------------------------------------------------------
// indexed_min_heap_edge_queue: binary min-heap of weighted edges
// Insert writes the new entry at the next free slot and climbs level by level
// while it is lighter than its parent; remove takes the root, moves the last
// entry to the root and sinks it level by level past the lighter child while
// that child is lighter; a rejected operation goes straight to the result
// register. Throughput: one operation at a time, the next accepted once the
// result has been taken, set by the single heap RAM port.
// Reset: count cleared, then a clearing pass over every entry of the
// vertex map (no transfer accepted meanwhile). Heap RAM is not cleared.
// ----------------------------------------------------------------------------
module indexed_min_heap_edge_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: edge_from[9:0], edge_to[19:10], edge_weight[51:20], zero [55:52]
  input  logic [55:0] s_axis_tdata,
  // tuser: operation[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: min_from[9:0], min_to[19:10], min_weight[51:20], entry_count[62:52], 0
  output logic [63:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]  m_axis_tuser
);
  localparam int unsigned SB = imheq_pkg::SlotBits;
  localparam int unsigned AB = imheq_pkg::AddrBits;
  localparam int unsigned VB = imheq_pkg::VtxBits;
  localparam int unsigned EW = $bits(imheq_pkg::entry_t);

  // state codes
  localparam logic [3:0] SClear = 4'd0, SIdle = 4'd1, SUpRd = 4'd2, SUpCmp = 4'd3,
                         SRmRoot = 4'd4, SRmLast = 4'd5, SDnL = 4'd6, SDnR = 4'd7,
                         SDnCmp = 4'd8, SOut = 4'd9, SUpWr = 4'd10, SDnWr = 4'd11,
                         SRmWr = 4'd12;

  logic [3:0]  st_q, st_d;
  logic [SB-1:0] cnt_q, cnt_d, pos_q, pos_d, oth_q, oth_d;
  imheq_pkg::entry_t cur_q, cur_d, lc_q, lc_d, oe_q, oe_d;
  logic        haveR_q, haveR_d;
  logic [VB:0] clr_q, clr_d;

  // result register
  logic        ov_q, ov_d;
  imheq_pkg::entry_t res_q, res_d;
  logic [1:0]  rst_q, rst_d;

  // heap RAM, slot s at address s-1
  logic          h_we;
  logic [AB-1:0] h_addr;
  imheq_pkg::entry_t h_wd, h_rd;
  imheq_ram #(.Width(EW), .Depth(imheq_pkg::Capacity)) u_heap (
    .clk_i(clk_i), .we_i(h_we), .addr_i(h_addr), .wdata_i(h_wd), .rdata_o(h_rd));

  // vertex map RAM, write only; a pending register can hold a queued write
  logic          m_we;
  logic [VB-1:0] m_addr;
  logic [SB-1:0] m_wd, m_rd;
  logic          pm_q, pm_d;
  logic [VB-1:0] pma_q, pma_d;
  logic [SB-1:0] pmd_q, pmd_d;
  imheq_ram #(.Width(SB), .Depth(imheq_pkg::VertexCount)) u_map (
    .clk_i(clk_i), .we_i(m_we), .addr_i(m_addr), .wdata_i(m_wd), .rdata_o(m_rd));

  imheq_pkg::entry_t in_e;
  assign in_e.from   = s_axis_tdata[9:0];
  assign in_e.to     = s_axis_tdata[19:10];
  assign in_e.weight = s_axis_tdata[51:20];

  assign s_axis_tready = (st_q == SIdle) && !ov_q && !pm_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {1'b0, cnt_q, res_q.weight, res_q.to, res_q.from};
  assign m_axis_tuser  = rst_q;

  function automatic logic [AB-1:0] adr(input logic [SB-1:0] s);
    logic [SB-1:0] t;
    t = s - SB'(1);
    return t[AB-1:0];
  endfunction

  function automatic logic inmap(input logic [9:0] v);
    return 32'(v) < imheq_pkg::VertexCount;
  endfunction

  // map write request from the sequencer (at most one per cycle)
  logic          mq_we;
  logic [VB-1:0] mq_a;
  logic [SB-1:0] mq_d;
  logic          mq2_we;
  logic [VB-1:0] mq2_a;
  logic [SB-1:0] mq2_d;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; pos_d = pos_q; oth_d = oth_q;
    cur_d = cur_q; lc_d = lc_q; oe_d = oe_q; haveR_d = haveR_q; clr_d = clr_q;
    ov_d = ov_q; res_d = res_q; rst_d = rst_q;
    h_we = 1'b0; h_addr = '0; h_wd = cur_q;
    mq_we = 1'b0; mq_a = '0; mq_d = '0;
    mq2_we = 1'b0; mq2_a = '0; mq2_d = '0;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    unique case (st_q)
      SClear: begin
        mq_we = 1'b1; mq_a = clr_q[VB-1:0]; mq_d = '0;
        clr_d = clr_q + (VB+1)'(1);
        if (32'(clr_q) == imheq_pkg::VertexCount - 1) st_d = SIdle;
      end
      SIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          res_d = '0; rst_d = imheq_pkg::StatusOk;
          if (s_axis_tuser == imheq_pkg::OpInsert) begin
            if (32'(cnt_q) >= imheq_pkg::Capacity) begin
              rst_d = imheq_pkg::StatusFull; st_d = SOut;
            end else begin
              cnt_d = cnt_q + SB'(1); pos_d = cnt_q + SB'(1);
              cur_d = in_e;
              h_we = 1'b1; h_addr = adr(cnt_q + SB'(1)); h_wd = in_e;
              if (inmap(in_e.to)) begin
                mq_we = 1'b1; mq_a = in_e.to[VB-1:0]; mq_d = cnt_q + SB'(1);
              end
              st_d = SUpRd;
            end
          end else if (cnt_q == '0) begin
            rst_d = imheq_pkg::StatusEmpty; st_d = SOut;
          end else begin
            h_addr = adr(SB'(1)); pos_d = SB'(1); st_d = SRmRoot;
          end
        end
      end
      SUpRd: begin
        if (pos_q == SB'(1)) st_d = SOut;
        else begin
          oth_d = pos_q >> 1; h_addr = adr(pos_q >> 1); st_d = SUpCmp;
        end
      end
      SUpCmp: begin
        if (cur_q.weight < h_rd.weight) begin
          oe_d = h_rd;
          h_we = 1'b1; h_addr = adr(oth_q); h_wd = cur_q;
          if (inmap(cur_q.to)) begin mq_we = 1'b1; mq_a = cur_q.to[VB-1:0]; mq_d = oth_q; end
          st_d = SUpWr;
        end else st_d = SOut;
      end
      SUpWr: begin
        h_we = 1'b1; h_addr = adr(pos_q); h_wd = oe_q;
        if (inmap(oe_q.to)) begin mq_we = 1'b1; mq_a = oe_q.to[VB-1:0]; mq_d = pos_q; end
        pos_d = oth_q; st_d = SUpRd;
      end
      SRmRoot: begin
        res_d = h_rd;
        if (inmap(h_rd.to)) begin mq_we = 1'b1; mq_a = h_rd.to[VB-1:0]; mq_d = '0; end
        cnt_d = cnt_q - SB'(1);
        if (cnt_q == SB'(1)) st_d = SOut;
        else begin h_addr = adr(cnt_q); st_d = SRmLast; end
      end
      SRmLast: begin
        cur_d = h_rd;
        h_we = 1'b1; h_addr = adr(SB'(1)); h_wd = h_rd;
        if (inmap(h_rd.to)) begin mq_we = 1'b1; mq_a = h_rd.to[VB-1:0]; mq_d = SB'(1); end
        st_d = SRmWr;
      end
      SRmWr, SDnWr: begin
        if (st_q == SDnWr) begin
          h_we = 1'b1; h_addr = adr(pos_q); h_wd = oe_q;
          if (inmap(oe_q.to)) begin mq_we = 1'b1; mq_a = oe_q.to[VB-1:0]; mq_d = pos_q; end
          pos_d = oth_q;
        end
        // next level: read left child
        if ((pos_d >= cnt_q) || ((SB+1)'(pos_d) * 2 > (SB+1)'(cnt_q))) st_d = SOut;
        else if (h_we) st_d = SDnL;
        else begin h_addr = adr(pos_d << 1); st_d = SDnR; end
      end
      SDnL: begin
        h_addr = adr(pos_q << 1); st_d = SDnR;
      end
      SDnR: begin
        lc_d = h_rd;
        haveR_d = ((SB+1)'(pos_q) * 2 + 1) <= (SB+1)'(cnt_q);
        h_addr = adr((pos_q << 1) | SB'(1));
        st_d = SDnCmp;
      end
      SDnCmp: begin
        if (haveR_q && (h_rd.weight < lc_q.weight) && (cur_q.weight > h_rd.weight)) begin
          oe_d = h_rd; oth_d = (pos_q << 1) | SB'(1);
          h_we = 1'b1; h_addr = adr((pos_q << 1) | SB'(1)); h_wd = cur_q;
          if (inmap(cur_q.to)) begin
            mq_we = 1'b1; mq_a = cur_q.to[VB-1:0]; mq_d = (pos_q << 1) | SB'(1);
          end
          st_d = SDnWr;
        end else if (lc_q.weight < cur_q.weight) begin
          oe_d = lc_q; oth_d = pos_q << 1;
          h_we = 1'b1; h_addr = adr(pos_q << 1); h_wd = cur_q;
          if (inmap(cur_q.to)) begin mq_we = 1'b1; mq_a = cur_q.to[VB-1:0]; mq_d = pos_q << 1; end
          st_d = SDnWr;
        end else st_d = SOut;
      end
      SOut: begin
        if (!ov_q) begin ov_d = 1'b1; st_d = SIdle; end
      end
      default: st_d = SIdle;
    endcase
  end

  // map port: the sequencer writes at most one per cycle; a pending write goes
  // first and the current request is queued behind it when they collide
  always_comb begin
    pm_d = 1'b0; pma_d = pma_q; pmd_d = pmd_q;
    m_we = mq_we; m_addr = mq_a; m_wd = mq_d;
    if (pm_q) begin
      m_we = 1'b1; m_addr = pma_q; m_wd = pmd_q;
      if (mq_we) begin pm_d = 1'b1; pma_d = mq_a; pmd_d = mq_d; end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SClear; cnt_q <= '0; clr_q <= '0; ov_q <= 1'b0; pm_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; clr_q <= clr_d; ov_q <= ov_d; pm_q <= pm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; oth_q <= oth_d; cur_q <= cur_d; lc_q <= lc_d; oe_q <= oe_d;
    haveR_q <= haveR_d; res_q <= res_d; rst_q <= rst_d; pma_q <= pma_d; pmd_q <= pmd_d;
  end

  logic unused_rd;
  assign unused_rd = ^{m_rd, mq2_we, mq2_a, mq2_d, s_axis_tdata[55:52]};
endmodule

// ----- bench/tb_indexed_min_heap_edge_queue.sv -----
// ----------------------------------------------------------------------------
// tb_indexed_min_heap_edge_queue: self-checking bench for the edge min-heap
// Streams insert/remove commands with random gaps and output backpressure.
// An in-bench heap and vertex map predict every result; each transfer out of
// the block is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_indexed_min_heap_edge_queue;

  typedef struct packed {
    logic        op;
    logic [9:0]  from;
    logic [9:0]  to;
    logic [31:0] weight;
  } heap_cmd_t;

  typedef struct packed {
    logic [9:0]  from;
    logic [9:0]  to;
    logic [31:0] weight;
    logic [1:0]  status;
    logic [10:0] count;
  } heap_rsp_t;

  localparam int unsigned StallLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  indexed_min_heap_edge_queue uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state: heap slots 1..model_count, map vertex -> slot
  imheq_pkg::entry_t model_heap [1:imheq_pkg::Capacity];
  logic [10:0] model_slot [imheq_pkg::VertexCount];
  int unsigned model_count;

  heap_cmd_t   pending_cmds [$];
  heap_rsp_t   expected_rsps [$];
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  bit          stim_done = 1'b0;
  bit          calm = 1'b0;   // long stretch with no idling on either side

  function automatic void swap_slots(int unsigned a, int unsigned b);
    imheq_pkg::entry_t t;
    t = model_heap[a];
    model_heap[a] = model_heap[b];
    model_heap[b] = t;
    model_slot[model_heap[a].to] = 11'(a);
    model_slot[model_heap[b].to] = 11'(b);
  endfunction

  function automatic heap_rsp_t predict_heap_op(heap_cmd_t c);
    heap_rsp_t   r;
    imheq_pkg::entry_t m;
    int unsigned p, l, rc;
    r = '0;
    if (c.op == imheq_pkg::OpInsert) begin
      if (model_count >= imheq_pkg::Capacity) begin
        r.status = imheq_pkg::StatusFull;
      end else begin
        model_count++;
        p = model_count;
        model_heap[p] = '{weight: c.weight, to: c.to, from: c.from};
        model_slot[c.to] = 11'(p);
        while (p / 2 != 0 && model_heap[p].weight < model_heap[p / 2].weight) begin
          swap_slots(p / 2, p);
          p = p / 2;
        end
        r.status = imheq_pkg::StatusOk;
      end
    end else if (model_count == 0) begin
      r.status = imheq_pkg::StatusEmpty;
    end else begin
      m = model_heap[1];
      r.from = m.from;
      r.to = m.to;
      r.weight = m.weight;
      r.status = imheq_pkg::StatusOk;
      model_slot[m.to] = '0;
      if (model_count != 1) begin
        model_heap[1] = model_heap[model_count];
        model_slot[model_heap[1].to] = 11'd1;
      end
      model_count--;
      p = 1;
      while (p < model_count) begin
        l = 2 * p;
        rc = l + 1;
        if (l > model_count) break;
        if (rc <= model_count && model_heap[rc].weight < model_heap[l].weight &&
            model_heap[p].weight > model_heap[rc].weight) begin
          swap_slots(rc, p);
          p = rc;
        end else if (model_heap[l].weight < model_heap[p].weight) begin
          swap_slots(l, p);
          p = l;
        end else begin
          break;
        end
      end
    end
    r.count = 11'(model_count);
    return r;
  endfunction

  function automatic heap_cmd_t rand_insert(logic [31:0] w);
    heap_cmd_t c;
    c.op = imheq_pkg::OpInsert;
    c.from = 10'($urandom_range(0, 1023));
    // narrow target range now and then so duplicate vertices are common
    c.to = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 7))
                                       : 10'($urandom_range(0, 1023));
    c.weight = w;
    return c;
  endfunction

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);      // many ties
      1: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic heap_cmd_t remove_cmd();
    heap_cmd_t c;
    c = '0;
    c.op = imheq_pkg::OpRemove;
    c.from = 10'($urandom);    // ignored fields still toggle
    c.to = 10'($urandom);
    c.weight = $urandom;
    return c;
  endfunction

  // Stimulus: directed corner cases, a fill to capacity and drain, then random phases that grow and drain
  initial begin : stimulus
    int unsigned level;
    int unsigned target;
    for (int i = 0; i < imheq_pkg::VertexCount; i++) model_slot[i] = '0;
    model_count = 0;
    // removal from empty heap
    pending_cmds.push_back(remove_cmd());
    // field extremes and equal weights
    pending_cmds.push_back('{imheq_pkg::OpInsert, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF});
    pending_cmds.push_back('{imheq_pkg::OpInsert, 10'h000, 10'h000, 32'h0000_0000});
    pending_cmds.push_back('{imheq_pkg::OpInsert, 10'h155, 10'h2AA, 32'h5555_5555});
    pending_cmds.push_back('{imheq_pkg::OpInsert, 10'h2AA, 10'h155, 32'hAAAA_AAAA});
    pending_cmds.push_back('{imheq_pkg::OpInsert, 10'h001, 10'h3FF, 32'h5555_5555});
    // duplicate target vertex
    pending_cmds.push_back('{imheq_pkg::OpInsert, 10'h002, 10'h155, 32'h0000_0001});
    pending_cmds.push_back('{imheq_pkg::OpInsert, 10'h003, 10'h155, 32'h0000_0001});
    for (int i = 0; i < 9; i++) pending_cmds.push_back(remove_cmd());
    // fill to capacity, then full inserts, then drain most of it
    for (int i = 0; i < imheq_pkg::Capacity; i++) begin
      pending_cmds.push_back(rand_insert(rand_weight()));
    end
    pending_cmds.push_back(rand_insert(32'h0));
    pending_cmds.push_back(rand_insert(32'hFFFF_FFFF));
    for (int i = 0; i < 700; i++) pending_cmds.push_back(remove_cmd());
    level = imheq_pkg::Capacity - 700;
    // random phases around a drifting fill level
    while (pending_cmds.size() < 1850) begin
      target = $urandom_range(0, 40);
      for (int i = 0; i < 60; i++) begin
        if ($urandom_range(0, 99) < ((level < target) ? 75 : 30)) begin
          pending_cmds.push_back(rand_insert(rand_weight()));
          level++;
        end else begin
          pending_cmds.push_back(remove_cmd());
          if (level > 0) level--;
        end
      end
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver
  always @(posedge clk_i) begin : driver
    heap_cmd_t c;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_rsps.push_back(predict_heap_op(pending_cmds.pop_front()));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_cmds.size() != 0 && (calm || $urandom_range(0, 99) >= 26)) begin
          c = pending_cmds[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= c.op;
          s_axis_tdata <= {4'b0, c.weight, c.to, c.from};
        end else begin
          s_axis_tvalid <= 1'b0;
          if (pending_cmds.size() == 0) stim_done <= 1'b1;
        end
      end
    end
  end

  // Note: the head of pending_cmds stays queued until its transfer completes.

  // Monitor and checker
  always @(posedge clk_i) begin : monitor
    heap_rsp_t e;
    if (rst_ni) begin
      if ($urandom_range(0, 499) == 0) calm <= !calm;
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 26);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected result transfer, tdata %h", m_axis_tdata);
          error_count++;
        end else begin
          e = expected_rsps.pop_front();
          if (m_axis_tdata[9:0] !== e.from) begin
            $error("min_from: expected %0d, actual %0d", e.from, m_axis_tdata[9:0]);
            error_count++;
          end
          if (m_axis_tdata[19:10] !== e.to) begin
            $error("min_to: expected %0d, actual %0d", e.to, m_axis_tdata[19:10]);
            error_count++;
          end
          if (m_axis_tdata[51:20] !== e.weight) begin
            $error("min_weight: expected %0d, actual %0d", e.weight, m_axis_tdata[51:20]);
            error_count++;
          end
          if (m_axis_tdata[62:52] !== e.count) begin
            $error("entry_count: expected %0d, actual %0d", e.count, m_axis_tdata[62:52]);
            error_count++;
          end
          if (m_axis_tuser !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, m_axis_tuser);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : finish_ctrl
    wait (rst_ni);
    while (!(stim_done && !s_axis_tvalid && expected_rsps.size() == 0) &&
           quiet_cycles < StallLimit) @(posedge clk_i);
    if (quiet_cycles >= StallLimit) begin
      $display("tb_indexed_min_heap_edge_queue: FAIL");
    end else begin
      repeat (100) @(posedge clk_i);
      if (error_count == 0 && expected_rsps.size() == 0) begin
        $display("tb_indexed_min_heap_edge_queue: PASS");
      end else begin
        $display("tb_indexed_min_heap_edge_queue: FAIL");
      end
    end
    $finish;
  end
endmodule
